// File: design/svc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svc_pkg: shared types and constants for the signed varint codec
// Word layouts for both channels, the command queued from front to back,
// and the fixed figures of the 7-bit group format.
// ----------------------------------------------------------------------------
package svc_pkg;

    localparam int VALUE_BITS_DEF  = 32;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int WORD_BITS       = 32;
    localparam int GROUP_BITS      = 7;
    localparam int CONT_MAX        = 4;
    localparam int SHIFT_MAX       = 63;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    typedef struct packed {
        logic                         operation;
        logic signed [WORD_BITS-1:0]  value;
        logic [7:0]                   data_byte;
        logic                         stream_end;
    } t_in_word;

    typedef struct packed {
        logic [7:0]                   out_byte;
        logic                         last_byte;
        logic signed [WORD_BITS-1:0]  decoded_value;
        logic                         decode_done;
        logic                         decode_error;
    } t_out_word;

    typedef enum logic [1:0] {
        K_ENCODE,
        K_DEC_CONT,
        K_DEC_LAST,
        K_DEC_END
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic [WORD_BITS-1:0]  payload;
    } t_cmd;

endpackage
`default_nettype wire

// File: design/svc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svc_queue: command queue between front and back
// Small register FIFO; the back pops at its own pace.
// ----------------------------------------------------------------------------
module svc_queue #(
    parameter int DEPTH = svc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  svc_pkg::t_cmd      i_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output svc_pkg::t_cmd      o_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    svc_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: design/svc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svc_front: input acceptance and classification
// Sorts each word into encode, decode continuation, decode final or stream
// end, narrows the value to the encode width and pushes it to the queue.
// ----------------------------------------------------------------------------
module svc_front #(
    parameter int VALUE_BITS = svc_pkg::VALUE_BITS_DEF
) (
    input  wire logic          i_valid,
    input  svc_pkg::t_in_word  i_word,
    output logic               o_stall,
    input  wire logic          i_q_full,
    output logic               o_push,
    output svc_pkg::t_cmd      o_cmd
);

    localparam int EB = (VALUE_BITS < svc_pkg::WORD_BITS) ? VALUE_BITS : svc_pkg::WORD_BITS;

    logic signed [EB-1:0] enc_val;

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;
    assign enc_val = i_word.value[EB-1:0];

    always_comb begin
        o_cmd.payload = {{(svc_pkg::WORD_BITS - 8){1'b0}}, i_word.data_byte};
        priority if (i_word.operation == svc_pkg::OP_ENCODE) begin
            o_cmd.kind    = svc_pkg::K_ENCODE;
            o_cmd.payload = svc_pkg::WORD_BITS'(enc_val);
        end else if (i_word.stream_end) begin
            o_cmd.kind = svc_pkg::K_DEC_END;
        end else if (i_word.data_byte[7]) begin
            o_cmd.kind = svc_pkg::K_DEC_CONT;
        end else begin
            o_cmd.kind = svc_pkg::K_DEC_LAST;
        end
    end

endmodule
`default_nettype wire

// File: design/svc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svc_back: encode sequencer, decode accumulator and output register
// Emits one encoded byte per cycle while i_stall is low; folds one decode
// byte per cycle into the running sum while the encoder is idle.
// ----------------------------------------------------------------------------
module svc_back #(
    parameter int VALUE_BITS = svc_pkg::VALUE_BITS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_valid,
    input  svc_pkg::t_cmd       i_q_cmd,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_stall,
    output svc_pkg::t_out_word  o_word
);

    localparam int WB = svc_pkg::WORD_BITS;
    localparam int GB = svc_pkg::GROUP_BITS;

    logic                      r_out_valid;
    svc_pkg::t_out_word        r_out;
    logic                      r_enc_busy;
    logic signed [WB-1:0]      r_x;
    logic [2:0]                r_cnt;
    logic [VALUE_BITS-1:0]     r_sum;
    logic [5:0]                r_shift;

    logic                      out_free;
    logic signed [WB-1:0]      enc_src;
    logic [2:0]                enc_cnt;
    logic                      enc_fits;
    logic                      enc_cont;
    logic                      do_enc, do_cont, do_last, do_end;
    logic [VALUE_BITS-1:0]     cont_term, last_term, total;
    logic signed [VALUE_BITS-1:0] total_s;
    logic [6:0]                shift_add;

    always_comb begin
        out_free  = !r_out_valid || !i_stall;
        enc_src   = r_enc_busy ? r_x : $signed(i_q_cmd.payload);
        enc_cnt   = r_enc_busy ? r_cnt : 3'd0;
        enc_fits  = (&enc_src[WB-1:GB-1]) || !(|enc_src[WB-1:GB-1]);
        enc_cont  = !enc_fits && (enc_cnt < 3'(svc_pkg::CONT_MAX));

        cont_term = {{(VALUE_BITS - GB){1'b0}}, i_q_cmd.payload[GB-1:0]} << r_shift;
        last_term = {{(VALUE_BITS - GB){i_q_cmd.payload[GB-1]}},
                     i_q_cmd.payload[GB-1:0]} << r_shift;
        total     = r_sum + last_term;
        total_s   = total;
        shift_add = {1'b0, r_shift} + 7'(GB);

        o_pop   = 1'b0;
        do_enc  = 1'b0;
        do_cont = 1'b0;
        do_last = 1'b0;
        do_end  = 1'b0;
        if (r_enc_busy) begin
            do_enc = out_free;
        end else if (i_q_valid) begin
            unique case (i_q_cmd.kind)
                svc_pkg::K_ENCODE: begin
                    do_enc = out_free;
                    o_pop  = out_free;
                end
                svc_pkg::K_DEC_CONT: begin
                    do_cont = 1'b1;
                    o_pop   = 1'b1;
                end
                svc_pkg::K_DEC_LAST: begin
                    do_last = out_free;
                    o_pop   = out_free;
                end
                svc_pkg::K_DEC_END: begin
                    do_end = out_free;
                    o_pop  = out_free;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_enc_busy  <= 1'b0;
            r_cnt       <= '0;
            r_sum       <= '0;
            r_shift     <= '0;
        end else begin
            if (out_free) begin
                r_out_valid <= do_enc || do_last || do_end;
            end
            if (do_enc) begin
                r_out.out_byte      <= {enc_cont, enc_src[GB-1:0]};
                r_out.last_byte     <= !enc_cont;
                r_out.decoded_value <= '0;
                r_out.decode_done   <= 1'b0;
                r_out.decode_error  <= 1'b0;
                r_x        <= enc_src >>> GB;
                r_cnt      <= enc_cnt + 3'd1;
                r_enc_busy <= enc_cont;
            end
            if (do_cont) begin
                r_sum   <= r_sum + cont_term;
                r_shift <= (shift_add > 7'(svc_pkg::SHIFT_MAX)) ?
                           6'(svc_pkg::SHIFT_MAX) : shift_add[5:0];
            end
            if (do_last || do_end) begin
                r_out.out_byte      <= '0;
                r_out.last_byte     <= 1'b0;
                r_out.decoded_value <= do_last ? WB'(total_s) : '0;
                r_out.decode_done   <= 1'b1;
                r_out.decode_error  <= do_end;
                r_sum   <= '0;
                r_shift <= '0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

    a_busy_holds_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_enc_busy |-> r_out_valid)
        else $error("encoder busy without a pending byte");

    a_cnt_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_enc_busy |-> (r_cnt <= 3'(svc_pkg::CONT_MAX)))
        else $error("too many continuation bytes");

    a_cont_marked : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.decode_done && !r_out.last_byte) |-> r_out.out_byte[7])
        else $error("continuation byte without its mark");

    a_last_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.last_byte) |-> !r_out.out_byte[7])
        else $error("final byte carries a continuation mark");

    a_err_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.decode_error) |->
            (r_out.decode_done && r_out.decoded_value == '0))
        else $error("error word carries a value");

endmodule
`default_nettype wire

// File: design/signed_varint_codec.sv
`default_nettype none
// ----------------------------------------------------------------------------
// signed_varint_codec: signed 7-bit group variable-length integer codec
// Encodes signed values into bytes (low group first, bit 7 marks more to
// come) and decodes such byte streams back into values.
//
// Input channel i_valid/o_stall/i_word: operation 0 encodes value,
// operation 1 decodes data_byte, or flags a stream end with stream_end.
// Output channel o_valid/i_stall/o_word: one word per encoded byte, and one
// word per finished decode (value 0 and decode_error on a stream end).
// Decode bytes with bit 7 set give no output word.
// Each input word is registered in the queue, its result in the output register.
// Encode gives 1 to 5 bytes per value, one byte per cycle from the encode
// sequencer while i_stall is low; decode folds each byte into the accumulator.
// A short queue decouples the input side from the sequencer, so input words
// are taken while results wait. When i_stall is high the output word holds and
// the back end pauses but for bit-7 decode bytes; once the queue fills, o_stall rises.
// Reset clears the queue, the output valid flag, the encoder state and the decode sum and shift count.
// ----------------------------------------------------------------------------
module signed_varint_codec #(
    parameter int VALUE_BITS  = svc_pkg::VALUE_BITS_DEF,
    parameter int QUEUE_DEPTH = svc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  svc_pkg::t_in_word   i_word,
    output logic                o_stall,
    output logic                o_valid,
    output svc_pkg::t_out_word  o_word,
    input  wire logic           i_stall
);

    logic           q_full, q_push, q_pop, q_valid;
    svc_pkg::t_cmd  front_cmd, q_cmd;

    svc_front #(
        .VALUE_BITS(VALUE_BITS)
    ) u_front (
        .i_valid  (i_valid),
        .i_word   (i_word),
        .o_stall  (o_stall),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (front_cmd)
    );

    svc_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    svc_back #(
        .VALUE_BITS(VALUE_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_pop     (q_pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_word    (o_word)
    );

endmodule
`default_nettype wire
